// File: rtl/core/text_to_u64_any_base_macros.svh
// assertion macros for the text to u64 parser
// no dependencies; included by the top level after its declarations
`ifndef TEXT_TO_U64_ANY_BASE_MACROS_SVH
`define TEXT_TO_U64_ANY_BASE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define T2U_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define T2U_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define T2U_ASSERT(lbl, clk, rst_n, prop, msg)
`define T2U_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/core/t2u_pkg.sv
// shared types, character codes and classifier functions for the text to u64 parser
// no dependencies
package t2u_pkg;

    // parser phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_DONE   = 7'b0000010,
        PH_SPACE  = 7'b0000100,
        PH_SIGNED = 7'b0001000,
        PH_LEAD0  = 7'b0010000,
        PH_PREFIX = 7'b0100000,
        PH_DIGITS = 7'b1000000
    } t_phase;

    localparam int RADIX_BITS = 6;
    localparam int ACC_BITS   = 64;

    typedef logic [RADIX_BITS-1:0] t_radix;
    typedef logic [ACC_BITS-1:0]   t_acc;

    localparam t_radix RADIX_RESET = 6'd10;
    localparam t_radix RADIX_DEC   = 6'd10;
    localparam t_radix RADIX_HEX   = 6'd16;
    localparam t_radix RADIX_OCT   = 6'd8;
    localparam t_radix RADIX_BIN   = 6'd2;
    localparam t_radix RADIX_AUTO  = 6'd0;

    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] LETTER_BIAS = 8'd10;

    function automatic logic is_num(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_low(input logic [7:0] c);
        return (c >= CH_A_LO) && (c <= CH_Z_LO);
    endfunction

    function automatic logic is_up(input logic [7:0] c);
        return (c >= CH_A_UP) && (c <= CH_Z_UP);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_num(c) || is_low(c) || is_up(c);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SP);
    endfunction

    // digit value 0..35, meaningful only for alphanumerics
    function automatic t_radix digit_of(input logic [7:0] c);
        logic [7:0] v;
        if (is_num(c)) begin
            v = c - CH_ZERO;
        end else if (is_low(c)) begin
            v = c - CH_A_LO + LETTER_BIAS;
        end else begin
            v = c - CH_A_UP + LETTER_BIAS;
        end
        return v[RADIX_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/t2u_if.sv
// valid/ready channel interfaces for the text to u64 parser
// no dependencies
interface t2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface t2u_out_if #(
    parameter int OFFSET_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [63:0]            value;
    logic                   formed;
    logic                   done_res;
    logic [OFFSET_BITS-1:0] end_offset;

    modport source (output valid, output value, output formed, output done_res,
                    output end_offset, input ready);
    modport sink   (input valid, input value, input formed, input done_res,
                    input end_offset, output ready);
endinterface

// File: rtl/core/text_to_u64_any_base.sv
// streaming strtoull-style parser: text bytes in, provisional 64-bit value out
// depends on t2u_pkg, t2u_if.sv and text_to_u64_any_base_macros.svh
//
// usage:
//   i_src carries one text byte per transfer; start_req marks the first byte of a
//   new string and abandons any string in progress
//   o_res carries one result per input transfer: the value so far with the sign
//   applied, a formed flag, a done flag and the offset just past the number
//   radix is written through i_cfg_wr_en / i_cfg_wr_data; the block leaves it to the user
//   to write it only while idle; it is latched at each start; 0 selects the base from the 0x / 0b / 0 prefix
// timing:
//   each input transfer's result is held in the output register from the next cycle;
//   one byte per cycle sustained while o_res.ready stays high, set by the single
//   64x6 multiply-add of the digit step between the parser state and the output register
// reset:
//   radix returns to 10, the parser goes idle and the output register empties;
//   bytes before the first start report value 0, formed 0, done 1, offset 0
// stall:
//   while a result waits in the output register and the sink holds ready low,
//   i_src.ready is low and the parser state holds
module text_to_u64_any_base #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  t2u_pkg::t_radix         i_cfg_wr_data,
    t2u_in_if.sink                  i_src,
    t2u_out_if.source               o_res
);
    import t2u_pkg::*;

    typedef logic [OFFSET_BITS-1:0] t_off;

    localparam t_off OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam t_off OFF_ONE = t_off'(1);

    // configuration and parser state
    t_radix r_radix;
    t_phase r_phase, n_phase;
    logic   r_neg, n_neg;
    t_radix r_base, n_base;
    t_acc   r_acc, n_acc;       // accumulator kept with the sign already applied
    t_off   r_pos, n_pos;
    t_off   r_end, n_end;

    // output register
    logic   r_out_valid;
    t_acc   r_out_value;
    logic   r_out_formed;
    logic   r_out_done;
    t_off   r_out_end;

    // per-byte decode
    logic   accept;
    logic   start;
    logic   active;
    logic   alnum;
    logic   space;
    t_radix dig;
    t_acc   dig_ext;
    t_acc   sdig;
    logic   neg0;
    t_radix base0;
    t_off   pos0;
    t_off   pos_inc;
    t_radix mul_base;
    t_acc   mac;
    logic   take_ok;
    logic   lead;
    t_radix first_base;
    logic   first_ok;
    logic   first_go;
    logic   n_formed;
    logic   n_done;

    assign i_src.ready = !r_out_valid || o_res.ready;
    assign accept      = i_src.valid && i_src.ready;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_wr_en) begin
            r_radix <= i_cfg_wr_data;
        end
    end

    // byte classification and the shared digit datapath
    always_comb begin
        start    = i_src.start_req;
        active   = start || !((r_phase == PH_IDLE) || (r_phase == PH_DONE));
        alnum    = is_alnum(i_src.ch);
        space    = is_space(i_src.ch);
        dig      = digit_of(i_src.ch);
        dig_ext  = {{(ACC_BITS-RADIX_BITS){1'b0}}, dig};
        neg0     = start ? 1'b0 : r_neg;
        base0    = start ? r_radix : r_base;
        pos0     = start ? '0 : r_pos;
        pos_inc  = (pos0 == OFF_MAX) ? pos0 : pos0 + OFF_ONE;
        // negating each digit keeps the accumulator in signed form: -(a*b+d) = (-a)*b - d
        sdig     = neg0 ? (t_acc'(0) - dig_ext) : dig_ext;
        // base 0 still pending after a leading zero means octal
        mul_base = (r_base == RADIX_AUTO) ? RADIX_OCT : r_base;
        mac      = r_acc * {{(ACC_BITS-RADIX_BITS){1'b0}}, mul_base} + sdig;
        take_ok  = alnum && (dig < mul_base);
        lead     = start ? !alnum : (r_phase == PH_SPACE);
        // any non-zero first digit settles an auto base to decimal
        first_base = ((base0 == RADIX_AUTO) && (i_src.ch != CH_ZERO)) ? RADIX_DEC : base0;
        first_ok   = alnum && ((first_base == RADIX_AUTO) || (dig < first_base));
    end

    // next parser state
    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_base   = r_base;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_end    = r_end;
        first_go = 1'b0;
        if (accept && active) begin
            n_neg  = neg0;
            n_base = base0;
            n_pos  = pos_inc;
            n_acc  = start ? '0 : r_acc;
            n_end  = start ? '0 : r_end;
            if (lead) begin
                // whitespace skip and optional sign
                if (space) begin
                    n_phase = PH_SPACE;
                end else if (i_src.ch == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (i_src.ch == CH_PLUS) begin
                    n_phase = PH_SIGNED;
                end else begin
                    first_go = 1'b1;
                end
            end else if (start) begin
                first_go = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_SIGNED: begin
                        first_go = 1'b1;
                    end
                    PH_LEAD0: begin
                        if (((i_src.ch == CH_X_LO) || (i_src.ch == CH_X_UP)) &&
                            ((r_base == RADIX_AUTO) || (r_base == RADIX_HEX))) begin
                            n_base  = RADIX_HEX;
                            n_phase = PH_PREFIX;
                        end else if (((i_src.ch == CH_B_LO) || (i_src.ch == CH_B_UP)) &&
                                     ((r_base == RADIX_AUTO) || (r_base == RADIX_BIN))) begin
                            n_base  = RADIX_BIN;
                            n_phase = PH_PREFIX;
                        end else begin
                            n_base = mul_base;
                            if (take_ok) begin
                                n_acc   = mac;
                                n_end   = pos_inc;
                                n_phase = PH_DIGITS;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    PH_PREFIX: begin
                        // prefix counts only when a digit of its base follows
                        if (alnum && (dig < r_base)) begin
                            n_acc   = sdig;
                            n_end   = pos_inc;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (take_ok) begin
                            n_acc   = mac;
                            n_end   = pos_inc;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            if (first_go) begin
                if (!first_ok) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_base = first_base;
                    n_acc  = sdig;
                    n_end  = pos_inc;
                    if ((i_src.ch == CH_ZERO) &&
                        ((first_base == RADIX_AUTO) || (first_base == RADIX_HEX) ||
                         (first_base == RADIX_BIN))) begin
                        n_phase = PH_LEAD0;
                    end else begin
                        n_phase = PH_DIGITS;
                    end
                end
            end
        end
        n_formed = (n_phase == PH_DONE) || (n_phase == PH_LEAD0) ||
                   (n_phase == PH_PREFIX) || (n_phase == PH_DIGITS);
        n_done   = (n_phase == PH_DONE) || (n_phase == PH_IDLE);
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_neg   <= 1'b0;
            r_base  <= RADIX_AUTO;
            r_acc   <= '0;
            r_pos   <= '0;
            r_end   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_end   <= n_end;
        end
    end

    // output register, loaded on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            // prefix still pending reports zero
            r_out_value  <= (n_formed && (n_phase != PH_PREFIX)) ? n_acc : '0;
            r_out_formed <= n_formed;
            r_out_done   <= n_done;
            r_out_end    <= n_formed ? n_end : '0;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_out_value;
    assign o_res.formed     = r_out_formed;
    assign o_res.done_res   = r_out_done;
    assign o_res.end_offset = r_out_end;

`include "text_to_u64_any_base_macros.svh"

    `T2U_ASSERT(a_result_follows, i_clk, i_rst_n, accept |=> r_out_valid, "transfer without result")
    `T2U_NEVER(a_unformed_zero, i_clk, i_rst_n, r_out_valid && !r_out_formed && ((r_out_value != '0) || (r_out_end != '0)), "unformed result not zero")
    `T2U_NEVER(a_formed_offset, i_clk, i_rst_n, r_out_valid && r_out_formed && (r_out_end == '0), "formed result with zero offset")

endmodule
